// File: rtl/pbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbd_pkg
// Types and constants shared by the byte-run planar row decoder.
// ----------------------------------------------------------------------------
package pbd_pkg;

  localparam int MAX_ROW_BYTES = 512;
  localparam int MAX_DEPTH     = 8;

  // Header byte that is skipped without a run (-128).
  localparam logic [7:0] HDR_SKIP = 8'h80;

  // Configuration register indexes.
  localparam logic [1:0] CFG_WIDTH_PIXELS = 2'd0;
  localparam logic [1:0] CFG_DEPTH        = 2'd1;
  localparam logic [1:0] CFG_COMPRESSED   = 2'd2;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_LITERAL = 3'b010,
    PH_REPEAT  = 3'b100
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  run_left;
    logic [2:0]  plane_index;
    logic [9:0]  byte_column;
    logic        discard_pending;
  } dec_state_t;

  typedef struct packed {
    logic [2:0] plane;
    logic [8:0] column;
    logic [7:0] run_length;
    logic [7:0] value;
    logic       row_done;
    logic       overflow;
  } run_t;

  // Effective row size, depth and compression mode, as held by the decoder.
  typedef struct packed {
    logic [9:0] row_bytes;
    logic [3:0] depth;
    logic       compressed;
  } dec_cfg_t;

endpackage

// File: rtl/pbd_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbd_step
// Next-state and run logic for one stream byte of the row decoder.
// ----------------------------------------------------------------------------
module pbd_step (
  input  pbd_pkg::dec_state_t st,
  input  pbd_pkg::dec_cfg_t   cfg,
  input  logic [7:0]          data_byte,
  output pbd_pkg::dec_state_t st_next,
  output logic                emit,
  output pbd_pkg::run_t       run
);
  import pbd_pkg::*;

  logic [9:0]  col_c;
  logic [2:0]  pl_c;
  logic [9:0]  avail;
  logic [7:0]  rep_len;
  logic [7:0]  rl_dec;
  logic [7:0]  len;
  logic [7:0]  len_c;
  logic        ovf;
  logic [10:0] col_sum;
  logic [3:0]  pl_inc;

  // A position left stale by a register write is pulled back into the row.
  assign col_c = (st.byte_column >= cfg.row_bytes) ? (cfg.row_bytes - 10'd1) : st.byte_column;
  assign pl_c  = ({1'b0, st.plane_index} >= cfg.depth) ? 3'(cfg.depth - 4'd1)
                                                       : st.plane_index;
  assign avail   = cfg.row_bytes - col_c;
  assign rep_len = (st.run_left == 8'd0) ? 8'd1 : st.run_left;
  assign rl_dec  = (st.run_left == 8'd0) ? 8'd0 : (st.run_left - 8'd1);

  assign len_c   = ({2'b00, len} > avail) ? avail[7:0] : len;
  assign col_sum = {1'b0, col_c} + {3'b000, len_c};
  assign pl_inc  = {1'b0, pl_c} + 4'd1;

  always_comb begin
    st_next = st;
    emit    = 1'b0;
    len     = 8'd1;
    ovf     = 1'b0;
    if (!cfg.compressed) begin
      st_next.phase           = PH_HEADER;
      st_next.run_left        = 8'd0;
      st_next.discard_pending = 1'b0;
      emit                    = 1'b1;
    end else begin
      case (st.phase)
        PH_LITERAL: begin
          st_next.run_left = rl_dec;
          st_next.phase    = (rl_dec == 8'd0) ? PH_HEADER : PH_LITERAL;
          if (st.discard_pending) begin
            if (rl_dec == 8'd0) begin
              st_next.discard_pending = 1'b0;
            end
          end else begin
            ovf  = ({1'b0, col_c} + 11'd1 >= {1'b0, cfg.row_bytes}) && (rl_dec != 8'd0);
            emit = 1'b1;
            if (ovf) begin
              st_next.discard_pending = 1'b1;
            end
          end
        end
        PH_REPEAT: begin
          len              = rep_len;
          ovf              = {2'b00, rep_len} > avail;
          emit             = 1'b1;
          st_next.phase    = PH_HEADER;
          st_next.run_left = 8'd0;
        end
        default: begin
          st_next.discard_pending = 1'b0;
          if (data_byte == HDR_SKIP) begin
            st_next.phase    = PH_HEADER;
            st_next.run_left = 8'd0;
          end else if (!data_byte[7]) begin
            st_next.phase    = PH_LITERAL;
            st_next.run_left = data_byte + 8'd1;
          end else begin
            st_next.phase    = PH_REPEAT;
            st_next.run_left = 8'(9'd257 - {1'b0, data_byte});
          end
        end
      endcase
    end

    run.plane      = pl_c;
    run.column     = col_c[8:0];
    run.run_length = len_c;
    run.value      = data_byte;
    run.overflow   = ovf;
    run.row_done   = 1'b0;

    if (emit) begin
      if (col_sum >= {1'b0, cfg.row_bytes}) begin
        st_next.byte_column = 10'd0;
        if (pl_inc >= cfg.depth) begin
          st_next.plane_index = 3'd0;
          run.row_done        = 1'b1;
        end else begin
          st_next.plane_index = pl_inc[2:0];
        end
      end else begin
        st_next.byte_column = col_sum[9:0];
        st_next.plane_index = pl_c;
      end
    end
  end

endmodule

// File: rtl/packbits_planar_row_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packbits_planar_row_decoder
// Byte-run (PackBits) decoder for bitplane image rows, one stream byte per beat.
// ----------------------------------------------------------------------------
// Pipeline: a byte that yields a run is held in the input register, decoded
// combinationally, and its run is then captured in the output register.
// Throughput: one byte per cycle unless stalled. Stalls only when the input and
// output registers are both full and the output beat is not being taken.
// Reset (synchronous): decoder waits for a header at plane 0, column 0;
// registers return to width 320, depth 1, compressed mode.
module packbits_planar_row_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  plane,
  output logic [8:0]  column,
  output logic [7:0]  run_length,
  output logic [7:0]  value,
  output logic        row_done,
  output logic        overflow
);
  import pbd_pkg::*;

  dec_cfg_t    cfg;
  logic        byte_valid;
  logic [7:0]  byte_reg;
  dec_state_t  st;
  dec_state_t  st_next;
  logic        emit;
  run_t        run;
  run_t        run_reg;
  logic        advance;

  function automatic logic [9:0] row_bytes_of(input logic [12:0] w);
    logic [10:0] rb;
    rb = 11'(({1'b0, w} + 14'd7) >> 3);
    if (rb == 11'd0) begin
      rb = 11'd1;
    end else if (rb > 11'(MAX_ROW_BYTES)) begin
      rb = 11'(MAX_ROW_BYTES);
    end
    return rb[9:0];
  endfunction

  function automatic logic [3:0] depth_of(input logic [3:0] d);
    logic [3:0] r;
    r = d;
    if (r == 4'd0) begin
      r = 4'd1;
    end else if (r > 4'(MAX_DEPTH)) begin
      r = 4'(MAX_DEPTH);
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.row_bytes  <= row_bytes_of(13'd320);
      cfg.depth      <= 4'd1;
      cfg.compressed <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIDTH_PIXELS: begin
          cfg.row_bytes <= row_bytes_of(cfg_data);
        end
        CFG_DEPTH: begin
          cfg.depth <= depth_of(cfg_data[3:0]);
        end
        CFG_COMPRESSED: cfg.compressed <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The output register moves whenever it is empty or being drained.
  assign advance  = !out_valid || out_ready;
  assign in_ready = !byte_valid || advance;

  pbd_step u_step (
    .st        (st),
    .cfg       (cfg),
    .data_byte (byte_reg),
    .st_next   (st_next),
    .emit      (emit),
    .run       (run)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid         <= 1'b0;
      out_valid          <= 1'b0;
      st.phase           <= PH_HEADER;
      st.run_left        <= 8'd0;
      st.plane_index     <= 3'd0;
      st.byte_column     <= 10'd0;
      st.discard_pending <= 1'b0;
    end else begin
      if (in_ready) begin
        byte_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= byte_valid && emit;
        if (byte_valid) begin
          st <= st_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_reg <= data_byte;
    end
    if (advance && byte_valid && emit) begin
      run_reg <= run;
    end
  end

  assign plane      = run_reg.plane;
  assign column     = run_reg.column;
  assign run_length = run_reg.run_length;
  assign value      = run_reg.value;
  assign row_done   = run_reg.row_done;
  assign overflow   = run_reg.overflow;

  // Dropping surplus literal bytes only happens inside a literal.
  a_discard_in_literal: assert property (@(posedge clk) disable iff (rst)
    st.discard_pending |-> st.phase == PH_LITERAL)
    else $error("discard pending outside a literal");

  // The input side stalls only behind a full, blocked output register.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> byte_valid && out_valid && !out_ready)
    else $error("input stalled without a blocked output");

  // A delivered run never reaches past the plane row end.
  a_run_in_row: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, column} + {2'b00, run_length} <= cfg.row_bytes) &&
                  (run_length != 8'd0))
    else $error("run extends past the row end");

  // Row completion is flagged only on the last plane.
  a_row_done_plane: assert property (@(posedge clk) disable iff (rst)
    out_valid && row_done |-> {1'b0, plane} == cfg.depth - 4'd1)
    else $error("row done on a plane other than the last");

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the byte-run planar row decoder. Drives header and
// data bytes under changing row sizes, depths and modes. Every accepted byte
// is decoded by a software copy of the decoder, and each output beat is
// compared field by field with the oldest predicted run.
// ----------------------------------------------------------------------------
module tb_top;
  import pbd_pkg::*;

  localparam int RUN_LIMIT    = 500000;
  localparam int DRAIN_CYCLES = 8;

  class run_scoreboard;
    logic [12:0] width_pixels;
    logic [3:0]  depth;
    logic        compressed;
    phase_t      phase;
    logic [7:0]  run_left;
    logic [2:0]  plane_index;
    logic [9:0]  byte_column;
    logic        discard_pending;
    run_t        expected_runs[$];
    int          errors;

    function new();
      width_pixels    = 13'd320;
      depth           = 4'd1;
      compressed      = 1'b1;
      phase           = PH_HEADER;
      run_left        = '0;
      plane_index     = '0;
      byte_column     = '0;
      discard_pending = 1'b0;
      errors          = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [12:0] val);
      case (idx)
        CFG_WIDTH_PIXELS: width_pixels = val;
        CFG_DEPTH:        depth = val[3:0];
        CFG_COMPRESSED:   compressed = val[0];
        default: ;
      endcase
    endfunction

    function int row_bytes();
      int rb;
      rb = (int'(width_pixels) + 7) / 8;
      if (rb < 1) rb = 1;
      if (rb > MAX_ROW_BYTES) rb = MAX_ROW_BYTES;
      return rb;
    endfunction

    function int plane_count();
      int dp;
      dp = int'(depth);
      if (dp < 1) dp = 1;
      if (dp > MAX_DEPTH) dp = MAX_DEPTH;
      return dp;
    endfunction

    // Places one run at the current position and advances past it.
    function void push_run(int len, logic [7:0] val, logic ovf);
      int   rb;
      int   dp;
      int   col;
      int   pl;
      run_t r;
      rb  = row_bytes();
      dp  = plane_count();
      col = int'(byte_column);
      pl  = int'(plane_index);
      if (col >= rb) col = rb - 1;
      if (pl >= dp) pl = dp - 1;
      if (len > rb - col) len = rb - col;
      r.plane      = pl[2:0];
      r.column     = col[8:0];
      r.run_length = len[7:0];
      r.value      = val;
      r.overflow   = ovf;
      r.row_done   = 1'b0;
      col += len;
      if (col >= rb) begin
        col = 0;
        pl++;
        if (pl >= dp) begin
          pl = 0;
          r.row_done = 1'b1;
        end
      end
      byte_column = col[9:0];
      plane_index = pl[2:0];
      expected_runs.push_back(r);
    endfunction

    function void decode_byte(logic [7:0] b);
      int   rb;
      int   col;
      int   len;
      logic ovf;
      if (!compressed) begin
        phase           = PH_HEADER;
        run_left        = '0;
        discard_pending = 1'b0;
        push_run(1, b, 1'b0);
        return;
      end
      rb  = row_bytes();
      col = int'(byte_column);
      if (col >= rb) col = rb - 1;
      case (phase)
        PH_LITERAL: begin
          if (run_left > 0) run_left--;
          if (run_left == 0) phase = PH_HEADER;
          if (discard_pending) begin
            if (run_left == 0) discard_pending = 1'b0;
          end else begin
            ovf = (col + 1 >= rb) && (run_left > 0);
            if (ovf) discard_pending = 1'b1;
            push_run(1, b, ovf);
          end
        end
        PH_REPEAT: begin
          len = (run_left < 1) ? 1 : int'(run_left);
          ovf = 1'b0;
          if (len > rb - col) begin
            len = rb - col;
            ovf = 1'b1;
          end
          phase    = PH_HEADER;
          run_left = '0;
          push_run(len, b, ovf);
        end
        default: begin
          discard_pending = 1'b0;
          if (b == HDR_SKIP) begin
            phase    = PH_HEADER;
            run_left = '0;
          end else if (b < HDR_SKIP) begin
            run_left = b + 8'd1;
            phase    = PH_LITERAL;
          end else begin
            run_left = 8'(257 - int'(b));
            phase    = PH_REPEAT;
          end
        end
      endcase
    endfunction

    function void compare_field(string name, logic [8:0] want, logic [8:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_run(run_t got);
      run_t want;
      if (expected_runs.size() == 0) begin
        errors++;
        $display("%0t: run with nothing expected, expected none, actual %p", $time, got);
        return;
      end
      want = expected_runs.pop_front();
      compare_field("plane", want.plane, got.plane);
      compare_field("column", want.column, got.column);
      compare_field("run_length", want.run_length, got.run_length);
      compare_field("value", want.value, got.value);
      compare_field("row_done", want.row_done, got.row_done);
      compare_field("overflow", want.overflow, got.overflow);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [12:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  data_byte;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  plane;
  logic [8:0]  column;
  logic [7:0]  run_length;
  logic [7:0]  value;
  logic        row_done;
  logic        overflow;

  run_scoreboard runs;
  int            send_idle_pct;
  int            recv_idle_pct;
  int            cycle_count;

  // Opening stream for a two-byte, two-plane row: clamped repeats, a literal
  // that runs past the row end, a zero header and skipped headers.
  logic [7:0] opening_bytes [19] = '{
    8'h00, 8'h00, HDR_SKIP, 8'hFF, 8'hFF, 8'h81, 8'h5A,
    8'h03, 8'h11, 8'h22, 8'h33, 8'h44, 8'hFE, 8'hA5,
    8'h01, 8'h7E, 8'h01, HDR_SKIP, HDR_SKIP
  };

  packbits_planar_row_decoder dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .plane      (plane),
    .column     (column),
    .run_length (run_length),
    .value      (value),
    .row_done   (row_done),
    .overflow   (overflow)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    if (rst) out_ready = 1'b0;
    else out_ready = ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      runs.check_run(run_t'({plane, column, run_length, value, row_done, overflow}));
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid  = 1'b1;
    data_byte = b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    runs.decode_byte(b);
  endtask

  // Holds the sender off until every predicted run is out and the pipeline
  // has had time to absorb any trailing header byte.
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (runs.expected_runs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    runs.write_reg(idx, val);
  endtask

  // One well-formed literal, repeat or skip, or now and then a stray byte.
  task automatic send_packet(output int sent);
    int         pick;
    logic [7:0] hdr;
    pick = $urandom_range(99);
    sent = 0;
    if (pick < 45) begin
      if ($urandom_range(15) == 0)
        hdr = ($urandom_range(3) == 0) ? 8'h7F : 8'($urandom_range(127));
      else
        hdr = 8'($urandom_range(7));
      send_byte(hdr);
      for (int i = 0; i <= int'(hdr); i++) send_byte(8'($urandom_range(255)));
      sent = int'(hdr) + 2;
    end else if (pick < 85) begin
      send_byte(8'($urandom_range(255, 129)));
      send_byte(8'($urandom_range(255)));
      sent = 2;
    end else if (pick < 90) begin
      send_byte(HDR_SKIP);
      sent = 1;
    end else begin
      send_byte(8'($urandom_range(255)));
      sent = 1;
    end
  endtask

  task automatic run_phase(input int w, input int d, input int c, input int items);
    int sent_items;
    int n;
    wait_idle();
    write_reg(CFG_WIDTH_PIXELS, 13'(w));
    write_reg(CFG_DEPTH, 13'(d));
    write_reg(CFG_COMPRESSED, 13'(c));
    sent_items = 0;
    while (sent_items < items) begin
      if (c == 0) begin
        send_byte(8'($urandom_range(255)));
        sent_items++;
      end else begin
        send_packet(n);
        sent_items += n;
      end
    end
  endtask

  initial begin
    runs          = new();
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    data_byte     = '0;
    send_idle_pct = 32;
    recv_idle_pct = 71;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    write_reg(CFG_WIDTH_PIXELS, 13'd16);
    write_reg(CFG_DEPTH, 13'd2);
    write_reg(CFG_COMPRESSED, 13'd1);
    foreach (opening_bytes[i]) send_byte(opening_bytes[i]);

    // Narrow rows first, then the widest, then a shrink that leaves the
    // column and plane stale.
    run_phase(1, 1, 1, 120);
    run_phase(0, 0, 1, 80);
    run_phase(4096, 8, 1, 200);
    run_phase(8, 2, 1, 100);

    send_idle_pct = 71;
    recv_idle_pct = 32;
    run_phase(8191, 15, 1, 150);
    run_phase(320, 4, 0, 100);
    run_phase(57, 5, 0, 60);
    run_phase(24, 3, 1, 150);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase($urandom_range(200, 1), $urandom_range(8, 1), 1, 150);
    run_phase(100, 2, 1, 150);
    wait_idle();

    if (runs.errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
